// ----- sv/sts_pkg.sv -----
// Shared types, token kind codes and character helpers for the script token scanner.
`default_nettype none

package sts_pkg;

  // Token kind codes.
  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_IF     = 5'd3;
  localparam logic [4:0] K_THEN   = 5'd4;
  localparam logic [4:0] K_ENDIF  = 5'd5;
  localparam logic [4:0] K_DEF    = 5'd6;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_MINUS  = 5'd8;
  localparam logic [4:0] K_STAR   = 5'd9;
  localparam logic [4:0] K_SLASH  = 5'd10;
  localparam logic [4:0] K_PCT    = 5'd11;
  localparam logic [4:0] K_ASSIGN = 5'd12;
  localparam logic [4:0] K_ARROW  = 5'd13;
  localparam logic [4:0] K_LPAREN = 5'd14;
  localparam logic [4:0] K_RPAREN = 5'd15;
  localparam logic [4:0] K_LBRACK = 5'd16;
  localparam logic [4:0] K_RBRACK = 5'd17;
  localparam logic [4:0] K_NEWLN  = 5'd18;
  localparam logic [4:0] K_COMMA  = 5'd19;
  localparam logic [4:0] K_QUEST  = 5'd20;
  localparam logic [4:0] K_COLON  = 5'd21;
  localparam logic [4:0] K_DOT    = 5'd22;
  localparam logic [4:0] K_ERROR  = 5'd23;

  // Token queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
  } q_sts_t;

  // Letters and underscore start or continue a word.
  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Single-character tokens; K_END means the byte is not one.
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    case (c)
      8'h2B:   op_kind = K_PLUS;
      8'h2D:   op_kind = K_MINUS;
      8'h2A:   op_kind = K_STAR;
      8'h2F:   op_kind = K_SLASH;
      8'h25:   op_kind = K_PCT;
      8'h28:   op_kind = K_LPAREN;
      8'h29:   op_kind = K_RPAREN;
      8'h5B:   op_kind = K_LBRACK;
      8'h5D:   op_kind = K_RBRACK;
      8'h0A:   op_kind = K_NEWLN;
      8'h2C:   op_kind = K_COMMA;
      8'h3F:   op_kind = K_QUEST;
      8'h3A:   op_kind = K_COLON;
      8'h2E:   op_kind = K_DOT;
      default: op_kind = K_END;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- sv/sts_front.sv -----
// Front end: accepts source bytes, tracks scan state and forms up to two tokens per byte.
`default_nettype none

module sts_front #(
  parameter int OFFSET_BITS = 16,
  parameter int TOK_W = 5 + 2 * OFFSET_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_ch,
  input  wire sts_pkg::q_sts_t    q_sts,
  output logic                    push,
  output logic [2*TOK_W:0]        push_entry
);

  // Scan modes.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_NUM     = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_EQ      = 3'd4;

  localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);

  logic [2:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [39:0]            prefix_r, prefix_nxt;
  logic [2:0]             len_r, len_nxt;

  logic                   accept;
  logic                   do_idle;
  logic [7:0]             c;
  logic [4:0]             opk;
  logic [4:0]             wkind;

  // Closing token of an open multi-byte token, and token of the byte itself.
  logic                   ct_v, it_v;
  logic [4:0]             ct_k, it_k;
  logic [OFFSET_BITS-1:0] ct_b, ct_e, it_b, it_e;
  logic [TOK_W-1:0]       ct_tok, it_tok;

  assign c        = in_ch;
  assign in_stall = q_sts.full;
  assign accept   = in_valid & ~q_sts.full;
  assign opk      = sts_pkg::op_kind(c);

  // Keyword match on the stored word prefix.
  always_comb begin
    if (len_r == 3'd2 && prefix_r == 40'h6966) begin
      wkind = sts_pkg::K_IF;
    end else if (len_r == 3'd4 && prefix_r == 40'h7468656E) begin
      wkind = sts_pkg::K_THEN;
    end else if (len_r == 3'd5 && prefix_r == 40'h656E646966) begin
      wkind = sts_pkg::K_ENDIF;
    end else if (len_r == 3'd3 && prefix_r == 40'h646566) begin
      wkind = sts_pkg::K_DEF;
    end else begin
      wkind = sts_pkg::K_IDENT;
    end
  end

  // Next scan state and emitted tokens for the current byte.
  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    do_idle    = 1'b0;
    ct_v = 1'b0; ct_k = sts_pkg::K_END; ct_b = start_r; ct_e = pos_r;
    it_v = 1'b0; it_k = sts_pkg::K_END; it_b = pos_r;   it_e = pos_r;

    unique case (mode_r)
      MODE_WORD: begin
        if (sts_pkg::is_letter(c) || sts_pkg::is_digit(c)) begin
          if (len_r < 3'd5) begin
            prefix_nxt = {prefix_r[31:0], c};
          end
          if (len_r < 3'd6) begin
            len_nxt = len_r + 3'd1;
          end
          pos_nxt = pos_r + ONE;
        end else begin
          ct_v       = 1'b1;
          ct_k       = wkind;
          prefix_nxt = '0;
          len_nxt    = '0;
          do_idle    = 1'b1;
        end
      end
      MODE_NUM: begin
        if (sts_pkg::is_digit(c)) begin
          pos_nxt = pos_r + ONE;
        end else begin
          ct_v    = 1'b1;
          ct_k    = sts_pkg::K_INT;
          do_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == 8'h0A || c == 8'h00) begin
          do_idle = 1'b1;
        end else begin
          pos_nxt = pos_r + ONE;
        end
      end
      MODE_EQ: begin
        ct_v = 1'b1;
        if (c == 8'h3E) begin
          ct_k     = sts_pkg::K_ARROW;
          ct_e     = pos_r + ONE;
          mode_nxt = MODE_IDLE;
          pos_nxt  = pos_r + ONE;
        end else begin
          ct_k    = sts_pkg::K_ASSIGN;
          ct_e    = start_r + ONE;
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Handling of a byte seen between tokens.
    if (do_idle) begin
      mode_nxt = MODE_IDLE;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
        pos_nxt = pos_r + ONE;
      end else if (c == 8'h23) begin
        mode_nxt = MODE_COMMENT;
        pos_nxt  = pos_r + ONE;
      end else if (c == 8'h00) begin
        it_v       = 1'b1;
        it_k       = sts_pkg::K_END;
        pos_nxt    = '0;
        start_nxt  = '0;
        prefix_nxt = '0;
        len_nxt    = '0;
      end else if (sts_pkg::is_letter(c)) begin
        start_nxt  = pos_r;
        prefix_nxt = {32'd0, c};
        len_nxt    = 3'd1;
        mode_nxt   = MODE_WORD;
        pos_nxt    = pos_r + ONE;
      end else if (sts_pkg::is_digit(c)) begin
        start_nxt = pos_r;
        mode_nxt  = MODE_NUM;
        pos_nxt   = pos_r + ONE;
      end else if (c == 8'h3D) begin
        start_nxt = pos_r;
        mode_nxt  = MODE_EQ;
        pos_nxt   = pos_r + ONE;
      end else begin
        it_v    = 1'b1;
        it_k    = (opk != sts_pkg::K_END) ? opk : sts_pkg::K_ERROR;
        it_e    = pos_r + ONE;
        pos_nxt = pos_r + ONE;
      end
    end
  end

  // Pack the queue entry: pair flag, first token, second token.
  assign ct_tok = {ct_k, ct_b, ct_e};
  assign it_tok = {it_k, it_b, it_e};
  assign push   = accept & (ct_v | it_v);
  assign push_entry = ct_v ? {it_tok, ct_tok, it_v} : {it_tok, it_tok, 1'b0};

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      start_r  <= '0;
      pos_r    <= '0;
      prefix_r <= '0;
      len_r    <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sts_fifo.sv -----
// Short token queue between the scanner front end and the output back end.
`default_nettype none

module sts_fifo #(
  parameter int WIDTH = 75
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output sts_pkg::q_sts_t       sts
);

  logic [WIDTH-1:0]          mem_r [sts_pkg::QDEPTH];
  logic [sts_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sts_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == (sts_pkg::QPTR_W + 1)'(sts_pkg::QDEPTH));
  assign do_push   = push & ~sts.full;
  assign do_pop    = pop & ~sts.empty;
  assign head      = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (sts_pkg::QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (sts_pkg::QPTR_W + 1)'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + sts_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + sts_pkg::QPTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sts_back.sv -----
// Back end: splits queued token pairs into single output transactions with a last flag.
`default_nettype none

module sts_back #(
  parameter int OFFSET_BITS = 16,
  parameter int TOK_W = 5 + 2 * OFFSET_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2*TOK_W:0]      head,
  input  wire sts_pkg::q_sts_t       q_sts,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [4:0]                 out_kind,
  output logic [OFFSET_BITS-1:0]     out_begin_offset,
  output logic [OFFSET_BITS-1:0]     out_end_offset,
  output logic                       out_last
);

  logic                   valid_r;
  logic                   second_r;
  logic                   load;
  logic                   pair;
  logic [TOK_W-1:0]       tok0, tok1, sel;
  logic [4:0]             kind_r;
  logic [OFFSET_BITS-1:0] beg_r, end_r;
  logic                   last_r;

  assign pair = head[0];
  assign tok0 = head[TOK_W:1];
  assign tok1 = head[2*TOK_W:TOK_W+1];
  assign sel  = second_r ? tok1 : tok0;

  // Load the output register when it is free or being taken.
  assign load = ~q_sts.empty & (~valid_r | ~out_stall);
  assign pop  = load & (second_r | ~pair);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        second_r <= ~second_r & pair;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= sel[TOK_W-1 -: 5];
      beg_r  <= sel[2*OFFSET_BITS-1 -: OFFSET_BITS];
      end_r  <= sel[OFFSET_BITS-1:0];
      last_r <= second_r | ~pair;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_begin_offset = beg_r;
  assign out_end_offset   = end_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

// ----- sv/script_token_scanner_top.sv -----
// Top level of the script token scanner: front end, token queue and back end.
// A token is written into a queue entry when the byte that ends it is accepted, then loaded into the output register.
// Throughput: one byte per cycle while in_stall is low; the output port moves one token per cycle
// while out_stall is low, so a byte that closes one token and forms another holds the port for both.
// The four-entry token queue absorbs such bursts before in_stall rises.
// Reset (synchronous, rst_n low) returns the scanner to idle at offset zero and empties the queue.
`default_nettype none

module script_token_scanner_top #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_ch,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [4:0]                  out_kind,
  output logic [OFFSET_BITS-1:0]      out_begin_offset,
  output logic [OFFSET_BITS-1:0]      out_end_offset,
  output logic                        out_last
);

  localparam int TOK_W = 5 + 2 * OFFSET_BITS;

  sts_pkg::q_sts_t   q_sts;
  logic              push, pop;
  logic [2*TOK_W:0]  push_entry, head;

  sts_front #(.OFFSET_BITS(OFFSET_BITS), .TOK_W(TOK_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .q_sts      (q_sts),
    .push       (push),
    .push_entry (push_entry)
  );

  sts_fifo #(.WIDTH(2 * TOK_W + 1)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head),
    .sts       (q_sts)
  );

  sts_back #(.OFFSET_BITS(OFFSET_BITS), .TOK_W(TOK_W)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_sts            (q_sts),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_begin_offset (out_begin_offset),
    .out_end_offset   (out_end_offset),
    .out_last         (out_last)
  );

  // The queue can never report full and empty together.
  a_q_sts: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_sts.full && q_sts.empty))
    else $error("token queue reports full and empty together");

  // An end-of-stream token is always the final token of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sts_pkg::K_END) |-> out_last)
    else $error("end token without last");

  // An end-of-stream token is empty.
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sts_pkg::K_END) |-> (out_begin_offset == out_end_offset))
    else $error("end token with nonzero extent");

  // An error token covers exactly one byte.
  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sts_pkg::K_ERROR) |->
      (out_end_offset == OFFSET_BITS'(out_begin_offset + OFFSET_BITS'(1))))
    else $error("error token does not cover one byte");

endmodule

`default_nettype wire
